/* rtl/abp_pkg.sv */
package abp_pkg;

    localparam int unsigned CHAN_W       = 8;
    localparam int unsigned WEIGHT_W     = 16;
    localparam int unsigned NUM_W        = 24;
    localparam int unsigned REM_W        = 17;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 16'd65025;
    localparam logic [WEIGHT_W-1:0] HALF_WEIGHT = 16'd32512;

    // floor(2^26 / 65025); the estimate is low by at most one
    localparam int unsigned         RECIP_SHIFT = 26;
    localparam int unsigned         RECIP_W     = 11;
    localparam logic [RECIP_W-1:0]  RECIP       = 11'd1032;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic [0:0]  REG_GLOBAL_ALPHA = 1'b0;
    localparam logic [CHAN_W-1:0] GLOBAL_ALPHA_RESET = 8'hFF;

    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
        logic en5;
    } t_stage_en;

endpackage

/* rtl/alpha_blend_pixel.sv */
// alpha_blend_pixel: source-over blend of an ARGB source pixel onto an RGB
// destination pixel, scaled by a global opacity register.
//
// Input channel: i_in_valid / o_in_stall carry i_src_pixel and i_dst_pixel.
// Output channel: o_out_valid / i_out_stall carry o_blended_pixel (R,G,B).
// A transaction completes on a clock edge with valid high and stall low.
//
// Pipeline of five register stages: alpha product, channel products,
// sum with rounding, reciprocal quotient estimate, remainder correction.
// The accepting edge loads stage one, and the result is valid once the pixel
// reaches stage five; throughput is one pixel per cycle while the output is
// not stalled. Each stage advances when it is empty or the next one moves,
// so a stall at the output backs up stage by stage and bubbles are squeezed
// out; nothing is dropped or repeated.
//
// APB port: global_alpha at address 0 (reads back), reset value 255.
// Write it only while the pipeline is empty.
//
// Reset (synchronous, active low) empties the pipeline and restores
// global_alpha.
module alpha_blend_pixel
    import abp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [31:0]       i_src_pixel,
    input  logic [31:0]       i_dst_pixel,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [23:0]       o_blended_pixel,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CHAN_W-1:0]   r_ga;
    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [WEIGHT_W-1:0] r_a1;
    logic [23:0]         r_src1, r_dst1;

    logic      w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic      w_en1;
    t_stage_en w_en;

    assign w_rdy5 = !r_v5 || !i_out_stall;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_en1  = w_rdy1;
    assign w_en.en2 = w_rdy2;
    assign w_en.en3 = w_rdy3;
    assign w_en.en4 = w_rdy4;
    assign w_en.en5 = w_rdy5;

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1)    r_v1 <= i_in_valid;
            if (w_en.en2) r_v2 <= r_v1;
            if (w_en.en3) r_v3 <= r_v2;
            if (w_en.en4) r_v4 <= r_v3;
            if (w_en.en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_a1   <= WEIGHT_W'(i_src_pixel[31:24]) * WEIGHT_W'(r_ga);
            r_src1 <= i_src_pixel[23:0];
            r_dst1 <= i_dst_pixel[23:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_chan
            abp_chan u_chan (
                .i_clk    (i_clk),
                .i_en     (w_en),
                .i_weight (r_a1),
                .i_src    (r_src1[g*CHAN_W +: CHAN_W]),
                .i_dst    (r_dst1[g*CHAN_W +: CHAN_W]),
                .o_chan   (o_blended_pixel[g*CHAN_W +: CHAN_W])
            );
        end
    endgenerate

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ga <= GLOBAL_ALPHA_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1] == REG_GLOBAL_ALPHA) begin
            r_ga <= pwdata[CHAN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_GLOBAL_ALPHA) ? DATA_W'(r_ga) : '0;

endmodule

/* rtl/abp_chan.sv */
module abp_chan
    import abp_pkg::*;
(
    input  logic                i_clk,
    input  t_stage_en           i_en,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic [CHAN_W-1:0]   i_src,
    input  logic [CHAN_W-1:0]   i_dst,
    output logic [CHAN_W-1:0]   o_chan
);

    localparam int unsigned PROD_W = NUM_W + RECIP_W;

    logic [NUM_W-1:0]  r_pd2, r_ps2;
    logic [NUM_W-1:0]  r_x3, r_x4;
    logic [CHAN_W-1:0] r_q4, r_q5;

    logic [WEIGHT_W-1:0] w_inv;
    logic [PROD_W-1:0]   w_est;
    logic [NUM_W-1:0]    w_back;
    logic [REM_W-1:0]    w_rem;

    assign w_inv  = FULL_WEIGHT - i_weight;
    assign w_est  = PROD_W'(r_x3) * PROD_W'(RECIP);
    assign w_back = NUM_W'(r_q4) * NUM_W'(FULL_WEIGHT);
    assign w_rem  = REM_W'(r_x4 - w_back);

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_pd2 <= NUM_W'(i_dst) * NUM_W'(w_inv);
            r_ps2 <= NUM_W'(i_src) * NUM_W'(i_weight);
        end
        if (i_en.en3) begin
            r_x3 <= r_pd2 + r_ps2 + NUM_W'(HALF_WEIGHT);
        end
        if (i_en.en4) begin
            r_x4 <= r_x3;
            r_q4 <= w_est[RECIP_SHIFT +: CHAN_W];
        end
        if (i_en.en5) begin
            // correct the low estimate by one when the remainder overflows
            r_q5 <= (w_rem >= REM_W'(FULL_WEIGHT)) ? r_q4 + 8'd1 : r_q4;
        end
    end

    assign o_chan = r_q5;

endmodule

/* tb/sv/alpha_blend_pixel_tb.sv */
module alpha_blend_pixel_tb;
    import abp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PIPE_SETTLE  = 10;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned STREAM_ITEMS = 150;
    localparam int unsigned MAX_REPORTS  = 10;

    // byte addresses of the register map; index 1 holds no register
    localparam logic [ADDR_W-1:0] GA_ADDR     = ADDR_W'(4 * REG_GLOBAL_ALPHA);
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [31:0]       i_src_pixel;
    logic [31:0]       i_dst_pixel;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [23:0]       o_blended_pixel;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [23:0]       pending_pixels[$];
    logic [23:0]       want_pixel;
    logic [CHAN_W-1:0] cur_global_alpha;
    logic              in_idle_on;
    logic              out_idle_on;
    int unsigned       error_count;
    int unsigned       pixels_sent;
    int unsigned       pixels_checked;
    int unsigned       cycle_count;

    alpha_blend_pixel dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_src_pixel     (i_src_pixel),
        .i_dst_pixel     (i_dst_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_blended_pixel (o_blended_pixel),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_pixels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= out_idle_on && ($urandom_range(0, 99) < 33);
    end

    // exact fixed-point src-over: weight in 1/65025 units, rounded half up
    function automatic logic [23:0] predict_blend(input logic [31:0] src,
                                                  input logic [31:0] dst,
                                                  input logic [CHAN_W-1:0] ga);
        int unsigned full, half, weight, num, s, d;
        logic [23:0] px;
        full   = 32'(FULL_WEIGHT);
        half   = 32'(HALF_WEIGHT);
        weight = int'(src[31:24]) * int'(ga);
        for (int ch = 0; ch < 3; ch++) begin
            s   = 32'(src[ch*8 +: 8]);
            d   = 32'(dst[ch*8 +: 8]);
            num = d * (full - weight) + s * weight;
            px[ch*8 +: 8] = 8'((num + half) / full);
        end
        return px;
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // alpha biased toward the pass-through corners, color mostly random
    function automatic logic [31:0] pick_src();
        int unsigned r;
        logic [7:0] alpha;
        r = $urandom_range(0, 9);
        if (r < 2)
            alpha = 8'h00;
        else if (r < 4)
            alpha = 8'hFF;
        else
            alpha = 8'($urandom);
        return {alpha, pick_byte(), pick_byte(), pick_byte()};
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result %06h at cycle %0d",
                             o_blended_pixel, cycle_count);
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (o_blended_pixel !== want_pixel) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("blended_pixel mismatch at cycle %0d: expected %06h, got %06h",
                                 cycle_count, want_pixel, o_blended_pixel);
                end
            end
        end
    end

    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
        if (in_idle_on && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_src_pixel <= src;
        i_dst_pixel <= dst;
        do @(posedge i_clk); while (o_in_stall);
        pending_pixels.push_back(predict_blend(src, dst, cur_global_alpha));
        pixels_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == GA_ADDR)
            cur_global_alpha = data[CHAN_W-1:0];
    endtask

    // upper bits of the write data carry junk; only the low byte counts
    task automatic set_global_alpha(input logic [CHAN_W-1:0] ga);
        wait_drained();
        apb_write(GA_ADDR, ($urandom & 32'hFFFF_FF00) | DATA_W'(ga));
    endtask

    task automatic test_reset_value();
        send_pixel(32'hFF11_2233, 32'h0044_5566);
        send_pixel(32'h00AA_BBCC, 32'hFF01_0203);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'h80FF_0000, 32'h0000_FFFF);
        send_pixel(32'h7F00_FF00, 32'hA5FF_00FF);
        send_pixel(32'h01FF_FFFF, 32'h0000_0000);
        send_pixel(32'hFE00_0000, 32'h5AFF_FFFF);
    endtask

    task automatic test_global_alpha_extremes();
        set_global_alpha(8'h00);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'hFF12_3456, 32'hC3AB_CDEF);
        set_global_alpha(8'h01);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h8080_8080, 32'h7F7F_7F7F);
        set_global_alpha(8'h80);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h01FF_FFFF, 32'hFF00_0000);
    endtask

    task automatic test_unused_register();
        wait_drained();
        apb_write(UNUSED_ADDR, 32'h0000_0010);
        send_pixel(32'hFF80_40C0, 32'h0010_2030);
        send_pixel(32'h40FF_FFFF, 32'h0000_0000);
        set_global_alpha(8'hFF);
    endtask

    task automatic test_random_blend();
        logic [CHAN_W-1:0] phase_alpha[6];
        phase_alpha = '{8'hFF, 8'h00, 8'h01, 8'hFE, 8'($urandom), 8'($urandom)};
        foreach (phase_alpha[p]) begin
            set_global_alpha(phase_alpha[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off once mid-phase until the pipeline is empty
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_pixel(pick_src(), $urandom);
            end
        end
    endtask

    task automatic test_back_to_back();
        set_global_alpha(8'($urandom));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        for (int n = 0; n < STREAM_ITEMS; n++)
            send_pixel(pick_src(), $urandom);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_src_pixel      <= '0;
        i_dst_pixel      <= '0;
        i_out_stall      <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        cycle_count      = 0;
        error_count      = 0;
        pixels_sent      = 0;
        pixels_checked   = 0;
        cur_global_alpha = GLOBAL_ALPHA_RESET;
        in_idle_on       = 1'b1;
        out_idle_on      = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_value();
        test_global_alpha_extremes();
        test_unused_register();
        test_random_blend();
        test_back_to_back();
        wait_drained();

        $display("blended %0d pixels, %0d results checked, %0d mismatches", pixels_sent,
                 pixels_checked, error_count);
        $display("global alpha at 0, 1, 128, 254, 255 and random; gaps, stalls, drain");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
